[src/rkht_pkg.sv]
package rkht_pkg;

    localparam int unsigned DEF_TABLE_DEPTH  = 256;
    localparam int unsigned DEF_SECRET_BYTES = 8;
    localparam int unsigned DEF_USAGE_WORD   = 0;
    localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        OP_ALLOC    = 4'd0,
        OP_FREE     = 4'd1,
        OP_EXISTS   = 4'd2,
        OP_READ     = 4'd3,
        OP_WRITE    = 4'd4,
        OP_REF_INC  = 4'd5,
        OP_REF_DEC  = 4'd6,
        OP_USE      = 4'd7,
        OP_USAGE_RD = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOKEY     = 3'd2,
        ST_NONZERO   = 3'd3,
        ST_SATURATED = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] key_slot;
        logic [63:0] key_secret;
        logic [63:0] ident_word0;
        logic [63:0] ident_word1;
        logic [63:0] ident_word2;
        logic [63:0] ident_word3;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] issued_index;
        logic [63:0] issued_secret;
        logic [63:0] read_word0;
        logic [63:0] read_word1;
        logic [63:0] read_word2;
        logic [63:0] read_word3;
        logic        present;
    } rsp_t;

    typedef struct packed {
        logic [63:0]      secret;
        logic [31:0]      count;
        logic             live;
        logic [3:0][63:0] words;
    } row_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_SCAN_CHK
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic rd_req;
        logic exec;
        logic scan_rd;
        logic scan_adv;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_busy;
        logic need_scan;
        logic scan_end;
        logic scan_hit;
    } stat_t;

endpackage

[src/rkht_ctrl.sv]
module rkht_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rkht_pkg::stat_t st,
    output rkht_pkg::cmd_t  cmd
);

    rkht_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rkht_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rkht_pkg::S_CLEAR: begin
                if (st.clr_done) state_next = rkht_pkg::S_IDLE;
            end
            rkht_pkg::S_IDLE: begin
                if (s_valid) state_next = rkht_pkg::S_READ;
            end
            rkht_pkg::S_READ: state_next = rkht_pkg::S_EXEC;
            rkht_pkg::S_EXEC: begin
                if (!st.out_busy) begin
                    state_next = st.need_scan ? rkht_pkg::S_SCAN : rkht_pkg::S_IDLE;
                end
            end
            rkht_pkg::S_SCAN: begin
                state_next = st.scan_end ? rkht_pkg::S_IDLE : rkht_pkg::S_SCAN_CHK;
            end
            rkht_pkg::S_SCAN_CHK: begin
                state_next = st.scan_hit ? rkht_pkg::S_SCAN : rkht_pkg::S_IDLE;
            end
            default: state_next = rkht_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rkht_pkg::S_CLEAR: cmd.clr_step = 1'b1;
            rkht_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            rkht_pkg::S_READ: cmd.rd_req = 1'b1;
            rkht_pkg::S_EXEC: cmd.exec = !st.out_busy;
            rkht_pkg::S_SCAN: cmd.scan_rd = !st.scan_end;
            rkht_pkg::S_SCAN_CHK: cmd.scan_adv = st.scan_hit;
            default: cmd = '0;
        endcase
    end

endmodule

[src/rkht_dp.sv]
module rkht_dp #(
    parameter int unsigned TABLE_DEPTH  = rkht_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned SECRET_BYTES = rkht_pkg::DEF_SECRET_BYTES,
    parameter int unsigned USAGE_WORD   = rkht_pkg::DEF_USAGE_WORD
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rkht_pkg::req_t   s_payload,
    output rkht_pkg::rsp_t   m_payload,
    output logic             m_valid,
    input  logic             m_ready,
    input  rkht_pkg::cmd_t   cmd,
    output rkht_pkg::stat_t  st
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned NFS_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [63:0] SECRET_MASK = (SECRET_BYTES >= 8) ? {64{1'b1}} :
                                          ((64'd1 << (8 * SECRET_BYTES)) - 64'd1);
    localparam logic [1:0]  UW = 2'(USAGE_WORD);

    rkht_pkg::row_t mem [TABLE_DEPTH];
    rkht_pkg::row_t rd_reg;
    rkht_pkg::req_t req_reg;
    rkht_pkg::rsp_t rsp_reg, rsp_next;
    logic           m_valid_reg;
    logic [ADDR_W-1:0] clr_ptr_reg;
    logic [NFS_W-1:0]  nfs_reg, nfs_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    rkht_pkg::row_t    wrow;
    logic              re;

    logic [63:0]       secret;
    logic              full, idx_ok;
    logic [ADDR_W-1:0] slot;
    logic [31:0]       dec_cnt;
    rkht_pkg::row_t    rel_row;

    assign secret = req_reg.key_secret & SECRET_MASK;
    assign full   = nfs_reg >= NFS_W'(TABLE_DEPTH);
    assign idx_ok = (req_reg.key_slot != 16'd0) &&
                    ({1'b0, req_reg.key_slot} <= 17'(TABLE_DEPTH));
    assign slot   = ADDR_W'(req_reg.key_slot - 16'd1);
    assign dec_cnt = (rd_reg.count != 32'd0) ? rd_reg.count - 32'd1 : 32'd0;

    always_comb begin
        rel_row        = '0;
        rel_row.secret = rd_reg.secret;
    end

    assign re    = cmd.rd_req || cmd.scan_rd;
    assign raddr = cmd.scan_rd ? nfs_reg[ADDR_W-1:0] :
                   (req_reg.opcode == rkht_pkg::OP_ALLOC) ? nfs_reg[ADDR_W-1:0] : slot;

    always_comb begin
        rsp_next = '0;
        we       = 1'b0;
        waddr    = slot;
        wrow     = rd_reg;
        nfs_next = nfs_reg;
        if (cmd.clr_step) begin
            we    = 1'b1;
            waddr = clr_ptr_reg;
            wrow  = '0;
        end else if (cmd.scan_adv) begin
            nfs_next = nfs_reg + NFS_W'(1);
        end else if (req_reg.opcode == rkht_pkg::OP_ALLOC) begin
            if (full) begin
                rsp_next.status = rkht_pkg::ST_FULL;
            end else begin
                we          = 1'b1;
                waddr       = nfs_reg[ADDR_W-1:0];
                wrow.secret = secret;
                wrow.count  = 32'd1;
                wrow.live   = 1'b1;
                wrow.words  = {req_reg.ident_word3, req_reg.ident_word2,
                               req_reg.ident_word1, req_reg.ident_word0};
                rsp_next.status        = rkht_pkg::ST_OK;
                rsp_next.issued_index  = 16'({1'b0, nfs_reg} + (NFS_W + 1)'(1));
                rsp_next.issued_secret = secret;
                nfs_next = nfs_reg + NFS_W'(1);
            end
        end else if (req_reg.opcode > rkht_pkg::OP_USAGE_RD || !idx_ok) begin
            rsp_next.status = rkht_pkg::ST_INVALID;
        end else if (rd_reg.secret != secret) begin
            rsp_next.status = rkht_pkg::ST_NOKEY;
        end else begin
            rsp_next.status = rkht_pkg::ST_OK;
            unique case (req_reg.opcode)
                rkht_pkg::OP_FREE: begin
                    if (rd_reg.count != 32'd0) begin
                        rsp_next.status = rkht_pkg::ST_NONZERO;
                    end else begin
                        we   = 1'b1;
                        wrow = rel_row;
                        if (NFS_W'(slot) < nfs_reg) nfs_next = NFS_W'(slot);
                    end
                end
                rkht_pkg::OP_EXISTS: rsp_next.present = rd_reg.live;
                rkht_pkg::OP_READ: begin
                    rsp_next.read_word0 = rd_reg.words[0];
                    rsp_next.read_word1 = rd_reg.words[1];
                    rsp_next.read_word2 = rd_reg.words[2];
                    rsp_next.read_word3 = rd_reg.words[3];
                end
                rkht_pkg::OP_WRITE: begin
                    we         = 1'b1;
                    wrow.words = {req_reg.ident_word3, req_reg.ident_word2,
                                  req_reg.ident_word1, req_reg.ident_word0};
                end
                rkht_pkg::OP_REF_INC: begin
                    if (rd_reg.count == rkht_pkg::COUNT_MAX) begin
                        rsp_next.status = rkht_pkg::ST_SATURATED;
                    end else begin
                        we         = 1'b1;
                        wrow.count = rd_reg.count + 32'd1;
                    end
                end
                rkht_pkg::OP_REF_DEC: begin
                    we = 1'b1;
                    if (dec_cnt == 32'd0) begin
                        wrow = rel_row;
                        if (NFS_W'(slot) < nfs_reg) nfs_next = NFS_W'(slot);
                    end else begin
                        wrow.count = dec_cnt;
                    end
                end
                rkht_pkg::OP_USE: begin
                    we             = 1'b1;
                    wrow.words[UW] = rd_reg.words[UW] + 64'd1;
                end
                default: rsp_next.read_word0 = rd_reg.words[UW];
            endcase
        end
        if (!cmd.exec && !cmd.clr_step && !cmd.scan_adv) begin
            we       = 1'b0;
            nfs_next = nfs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wrow;
        if (re) rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) req_reg <= s_payload;
        if (cmd.exec) rsp_reg <= rsp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            clr_ptr_reg <= '0;
            nfs_reg     <= '0;
        end else begin
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clr_step) clr_ptr_reg <= clr_ptr_reg + ADDR_W'(1);
            nfs_reg <= nfs_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_payload    = rsp_reg;
    assign st.clr_done  = clr_ptr_reg == ADDR_W'(TABLE_DEPTH - 1);
    assign st.out_busy  = m_valid_reg && !m_ready;
    assign st.need_scan = (req_reg.opcode == rkht_pkg::OP_ALLOC) && !full;
    assign st.scan_end  = full;
    assign st.scan_hit  = rd_reg.count != 32'd0;

endmodule

[src/refcounted_key_handle_table_unit.sv]
// channel   ports                         direction
// request   s_valid s_ready s_payload     in
// result    m_valid m_ready m_payload     out
//
// after reset a clearing pass writes every table slot to zero before s_ready rises
// each request passes capture, one slot memory read and execute, which writes the slot when the op changes it
// allocate then scans on for the next free slot, a read state and a check state per slot; no read if the table is full
// a result waits in the output register; a stalled result holds the next request in execute
module refcounted_key_handle_table_unit #(
    parameter int unsigned TABLE_DEPTH  = rkht_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned SECRET_BYTES = rkht_pkg::DEF_SECRET_BYTES,
    parameter int unsigned USAGE_WORD   = rkht_pkg::DEF_USAGE_WORD
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rkht_pkg::req_t s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output rkht_pkg::rsp_t m_payload
);

    rkht_pkg::cmd_t  cmd;
    rkht_pkg::stat_t st;

    rkht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rkht_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SECRET_BYTES (SECRET_BYTES),
        .USAGE_WORD   (USAGE_WORD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
